@@ rtl/rubc_pkg.sv @@
// rubc_pkg: shared types and constants for the utilization bound check unit
// holds the status codes, the sequencer states and the bound rom
// no dependencies
package rubc_pkg;

    localparam int SUM_W     = 24;  // utilization sum width
    localparam int CNT_W     = 6;   // task counter width
    localparam int BOUND_W   = 17;  // reported bound width
    localparam int BND_EXT_W = 25;  // bound width after scaling up to 24 fraction bits
    localparam int TICK_W    = 16;  // wcet and period width
    localparam int QUO_MAX_W = 40;  // widest quotient the divider can produce

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_PERIOD = 2'd1,
        ST_TOO_MANY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ACC,
        S_VERDICT
    } t_state;

    // n(2^(1/n)-1) in q.16, rounded to nearest, entry 0 unused
    localparam logic [BOUND_W-1:0] LL_BOUND_ROM [64] = '{
        17'd0,     17'd65536, 17'd54292, 17'd51103, 17'd49600, 17'd48725, 17'd48154, 17'd47751,
        17'd47452, 17'd47221, 17'd47037, 17'd46888, 17'd46764, 17'd46659, 17'd46569, 17'd46492,
        17'd46424, 17'd46365, 17'd46312, 17'd46265, 17'd46222, 17'd46184, 17'd46149, 17'd46118,
        17'd46088, 17'd46062, 17'd46037, 17'd46014, 17'd45993, 17'd45973, 17'd45955, 17'd45938,
        17'd45922, 17'd45907, 17'd45892, 17'd45879, 17'd45866, 17'd45854, 17'd45843, 17'd45832,
        17'd45822, 17'd45812, 17'd45803, 17'd45794, 17'd45786, 17'd45778, 17'd45770, 17'd45763,
        17'd45756, 17'd45749, 17'd45742, 17'd45736, 17'd45730, 17'd45724, 17'd45719, 17'd45714,
        17'd45708, 17'd45703, 17'd45699, 17'd45694, 17'd45689, 17'd45685, 17'd45681, 17'd45677
    };

endpackage

@@ rtl/rubc_div.sv @@
// rubc_div: restoring unsigned divider, one quotient bit per cycle
// divides a DW-bit dividend by a 16-bit nonzero divisor
// depends on rubc_pkg
module rubc_div
    import rubc_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [TICK_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_quo;
    logic [TICK_W:0]   r_rem;
    logic [TICK_W-1:0] r_div;

    logic [TICK_W:0]   rem_sh;
    logic              ge;

    // shift in the next dividend bit and try a subtract
    assign rem_sh = {r_rem[TICK_W-1:0], r_quo[DW-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});

    assign o_done     = (r_cnt == CW'(1));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
        end
    end

endmodule

@@ rtl/rm_utilization_bound_check_unit.sv @@
// rm_utilization_bound_check_unit: rate-monotonic admission test top level
// sequencer, utilization accumulator and verdict register around rubc_div
// depends on rubc_pkg and rubc_div
//
// Each task beat (wcet, period, last flag) adds floor(wcet * 2^FRACTION_BITS / period) to a
// saturating 24-bit utilization sum and bumps the task count. The share comes out of one
// restoring divider that produces a quotient bit per cycle. A task with a nonzero period
// passes S_DIV and then S_ACC, a zero-period task goes straight to S_ACC, and a last task
// then moves to S_VERDICT to load the verdict and waits there while the previous verdict
// still waits on the output. The input is not ready until the sequencer is back in S_IDLE.
// The verdict compares the sum against n(2^(1/n)-1) from a 64-entry rom, then the sum,
// count and status clear for the next set. A zero period or a task beyond MAX_TASKS sets
// an error status (first one sticks) and forces unschedulable.
// The verdict sits in an output register, so the next set can start while it waits.
module rm_utilization_bound_check_unit
    import rubc_pkg::*;
#(
    parameter int MAX_TASKS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TICK_W-1:0]  i_task_wcet,
    input  logic [TICK_W-1:0]  i_task_period,
    input  logic               i_last_task,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_schedulable,
    output logic [SUM_W-1:0]   o_utilization_q16,
    output logic [BOUND_W-1:0] o_bound_q16,
    output logic [CNT_W-1:0]   o_task_count,
    output logic [1:0]         o_status
);

    localparam int DW   = TICK_W + FRACTION_BITS;
    localparam int UP   = (FRACTION_BITS >= 16) ? (FRACTION_BITS - 16) : 0;
    localparam int DOWN = (FRACTION_BITS < 16) ? (16 - FRACTION_BITS) : 0;

    t_state r_state, n_state;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_err, n_err;
    logic             r_zero;
    logic             r_last;

    logic               r_out_valid;
    logic               r_out_sched;
    logic [SUM_W-1:0]   r_out_sum;
    logic [BOUND_W-1:0] r_out_bound;
    logic [CNT_W-1:0]   r_out_count;
    t_status            r_out_status;

    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [QUO_MAX_W-1:0] quo_ext;
    logic [SUM_W:0]       sum_add;
    logic [BND_EXT_W-1:0] bound;
    logic                 sched;
    logic                 out_free;
    logic                 load_out;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign div_start = accept && (i_task_period != '0);
    assign out_free  = !r_out_valid || i_ready;

    rubc_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({i_task_wcet, {FRACTION_BITS{1'b0}}}),
        .i_divisor  (i_task_period),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // saturating add of the share
    assign quo_ext = QUO_MAX_W'(div_quo);
    assign sum_add = {1'b0, r_sum} + {1'b0, quo_ext[SUM_W-1:0]};

    assign bound = (BND_EXT_W'(LL_BOUND_ROM[r_count]) << UP) >> DOWN;
    assign sched = (r_err == ST_OK) && (BND_EXT_W'(r_sum) <= bound);

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_count  = r_count;
        n_err    = r_err;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_task_period != '0) ? S_DIV : S_ACC;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_zero) begin
                    if (n_err == ST_OK) begin
                        n_err = ST_ZERO_PERIOD;
                    end
                end else if (sum_add[SUM_W] || (quo_ext[QUO_MAX_W-1:SUM_W] != '0)) begin
                    n_sum = '1;
                end else begin
                    n_sum = sum_add[SUM_W-1:0];
                end
                if (r_count >= CNT_W'(MAX_TASKS)) begin
                    n_count = CNT_W'(MAX_TASKS);
                    if (n_err == ST_OK) begin
                        n_err = ST_TOO_MANY;
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = r_last ? S_VERDICT : S_IDLE;
            end
            S_VERDICT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_sum    = '0;
                    n_count  = '0;
                    n_err    = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_count <= '0;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_zero <= (i_task_period == '0);
            r_last <= i_last_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_sched  <= sched;
            r_out_sum    <= r_sum;
            r_out_bound  <= bound[BOUND_W-1:0];
            r_out_count  <= r_count;
            r_out_status <= r_err;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_schedulable     = r_out_sched;
    assign o_utilization_q16 = r_out_sum;
    assign o_bound_q16       = r_out_bound;
    assign o_task_count      = r_out_count;
    assign o_status          = r_out_status;

endmodule

@@ rtl/rubc_chk.sv @@
// rubc_chk: port-level checks for rm_utilization_bound_check_unit
// bound to the top level at the end of this file
// depends on rubc_pkg
module rubc_chk
    import rubc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [TICK_W-1:0]  i_task_wcet,
    input logic [TICK_W-1:0]  i_task_period,
    input logic               i_last_task,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_schedulable,
    input logic [SUM_W-1:0]   o_utilization_q16,
    input logic [BOUND_W-1:0] o_bound_q16,
    input logic [CNT_W-1:0]   o_task_count,
    input logic [1:0]         o_status
);

    // a waiting task beat holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_task_wcet)
            && $stable(i_task_period) && $stable(i_last_task))
        else $error("task beat changed while waiting");

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_utilization_q16)
            && $stable(o_schedulable) && $stable(o_status)
            && $stable(o_bound_q16) && $stable(o_task_count))
        else $error("result beat changed while stalled");

    // accepting a task always drops the input ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after accepting a task");

    // a verdict always covers at least one task
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_task_count != '0)
        else $error("verdict with zero tasks");

    // any error status forces unschedulable
    a_err_unsched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> !o_schedulable)
        else $error("schedulable verdict with error status");

endmodule

bind rm_utilization_bound_check_unit rubc_chk u_rubc_chk (.*);

@@ test/testbench.sv @@
// testbench: self-checking bench for rm_utilization_bound_check_unit
// predicts each set verdict in the bench, drives task beats with bursty gaps, checks every verdict
// depends on rubc_pkg and the rtl of rm_utilization_bound_check_unit
module testbench
    import rubc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TASKS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BEATS  = 1450;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_REPORTS   = 10;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;

    // n(2^(1/n)-1) in q.16, rounded to nearest
    localparam logic [BOUND_W-1:0] LL_BOUND_Q16 [64] = '{
        17'd0,     17'd65536, 17'd54292, 17'd51103, 17'd49600, 17'd48725, 17'd48154, 17'd47751,
        17'd47452, 17'd47221, 17'd47037, 17'd46888, 17'd46764, 17'd46659, 17'd46569, 17'd46492,
        17'd46424, 17'd46365, 17'd46312, 17'd46265, 17'd46222, 17'd46184, 17'd46149, 17'd46118,
        17'd46088, 17'd46062, 17'd46037, 17'd46014, 17'd45993, 17'd45973, 17'd45955, 17'd45938,
        17'd45922, 17'd45907, 17'd45892, 17'd45879, 17'd45866, 17'd45854, 17'd45843, 17'd45832,
        17'd45822, 17'd45812, 17'd45803, 17'd45794, 17'd45786, 17'd45778, 17'd45770, 17'd45763,
        17'd45756, 17'd45749, 17'd45742, 17'd45736, 17'd45730, 17'd45724, 17'd45719, 17'd45714,
        17'd45708, 17'd45703, 17'd45699, 17'd45694, 17'd45689, 17'd45685, 17'd45681, 17'd45677
    };

    typedef struct packed {
        logic               schedulable;
        logic [SUM_W-1:0]   utilization;
        logic [BOUND_W-1:0] bound;
        logic [CNT_W-1:0]   count;
        t_status            status;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [TICK_W-1:0]  i_task_wcet;
    logic [TICK_W-1:0]  i_task_period;
    logic               i_last_task;
    logic               o_valid;
    logic               i_ready;
    logic               o_schedulable;
    logic [SUM_W-1:0]   o_utilization_q16;
    logic [BOUND_W-1:0] o_bound_q16;
    logic [CNT_W-1:0]   o_task_count;
    logic [1:0]         o_status;

    // running set state of the predictor
    logic [SUM_W-1:0]   util_sum;
    logic [CNT_W-1:0]   set_count;
    t_status            set_status;
    t_verdict           verdict_q[$];

    int  beats_sent;
    int  burst_left;
    bit  gaps_on;
    int  cycle_count;
    int  mismatches;
    int  n_verdicts, n_sched, n_zero_period, n_too_many, n_saturated;

    logic [15:0] ready_pattern;
    int          ready_phase;

    rm_utilization_bound_check_unit #(
        .MAX_TASKS    (MAX_TASKS),
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_task_wcet      (i_task_wcet),
        .i_task_period    (i_task_period),
        .i_last_task      (i_last_task),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_schedulable    (o_schedulable),
        .o_utilization_q16(o_utilization_q16),
        .o_bound_q16      (o_bound_q16),
        .o_task_count     (o_task_count),
        .o_status         (o_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdict_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, drawn anew at random from four kinds
    always @(negedge i_clk) begin
        if (ready_phase % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    ready_pattern = 16'hFFFF;
                end
                1: begin
                    ready_pattern = 16'($urandom);
                end
                2: begin
                    ready_pattern = 16'($urandom & $urandom & $urandom);
                end
                default: begin
                    ready_pattern = 16'h8000;
                end
            endcase
        end
        i_ready <= ready_pattern[ready_phase % 16];
        ready_phase++;
    end

    function automatic void admit_task(input logic [TICK_W-1:0] wcet,
                                       input logic [TICK_W-1:0] period,
                                       input logic last);
        longint unsigned share, total, bnd;
        t_verdict v;
        if (period == '0) begin
            if (set_status == ST_OK) set_status = ST_ZERO_PERIOD;
        end else begin
            share = (longint'(wcet) << FRAC_BITS) / period;
            total = longint'(util_sum) + share;
            util_sum = (total > longint'(SUM_SAT)) ? SUM_SAT : total[SUM_W-1:0];
        end
        if (set_count >= MAX_TASKS) begin
            set_count = CNT_W'(MAX_TASKS);
            if (set_status == ST_OK) set_status = ST_TOO_MANY;
        end else begin
            set_count = set_count + 1'b1;
        end
        if (!last) return;

        bnd = longint'(LL_BOUND_Q16[set_count]);
        if (FRAC_BITS >= 16) bnd = bnd << (FRAC_BITS - 16);
        else bnd = bnd >> (16 - FRAC_BITS);
        v.schedulable = (set_status == ST_OK) && (longint'(util_sum) <= bnd);
        v.utilization = util_sum;
        v.bound       = bnd[BOUND_W-1:0];
        v.count       = set_count;
        v.status      = set_status;
        verdict_q.push_back(v);

        n_verdicts++;
        if (v.schedulable) n_sched++;
        if (set_status == ST_ZERO_PERIOD) n_zero_period++;
        if (set_status == ST_TOO_MANY) n_too_many++;
        if (util_sum == SUM_SAT) n_saturated++;
        util_sum   = '0;
        set_count  = '0;
        set_status = ST_OK;
    endfunction

    // one task beat; returns at the falling edge after it was taken
    task automatic send_task_beat(input logic [TICK_W-1:0] wcet,
                                  input logic [TICK_W-1:0] period,
                                  input logic last);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(13, 45)
                                                  : $urandom_range(1, 12))
                    @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_task_wcet   <= wcet;
        i_task_period <= period;
        i_last_task   <= last;
        do @(posedge i_clk); while (!o_ready);
        admit_task(wcet, period, last);
        beats_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_schedulable, o_utilization_q16, o_bound_q16, o_task_count,
                   t_status'(o_status)};
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected verdict: sched=%0b util=%h bound=%h count=%0d status=%0d",
                             got.schedulable, got.utilization, got.bound, got.count,
                             got.status);
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("verdict mismatch at cycle %0d", cycle_count);
                        $display("  expected sched=%0b util=%h bound=%h count=%0d status=%0d",
                                 want.schedulable, want.utilization, want.bound, want.count,
                                 want.status);
                        $display("  actual   sched=%0b util=%h bound=%h count=%0d status=%0d",
                                 got.schedulable, got.utilization, got.bound, got.count,
                                 got.status);
                    end
                end
            end
        end
    end

    // single-task extremes, exact bound hit, just over the bound, zero period
    task automatic test_edge_sets();
        gaps_on = 1'b0;
        send_task_beat(16'd0, 16'd1, 1'b1);
        send_task_beat(16'hFFFF, 16'd1, 1'b1);          // saturates the sum
        send_task_beat(16'hFFFF, 16'hFFFF, 1'b1);       // exactly on the bound
        send_task_beat(16'd1, 16'hFFFF, 1'b1);
        send_task_beat(16'hAAAA, 16'h5555, 1'b1);
        send_task_beat(16'h5555, 16'hAAAA, 1'b1);
        send_task_beat(16'd1, 16'd4, 1'b0);
        send_task_beat(16'd1, 16'd2, 1'b1);             // under the two-task bound
        send_task_beat(16'd1, 16'd2, 1'b0);
        send_task_beat(16'd1, 16'd3, 1'b1);             // just over it
        send_task_beat(16'd100, 16'd0, 1'b1);
        send_task_beat(16'hFFFF, 16'd0, 1'b0);
        send_task_beat(16'd3, 16'd7, 1'b1);
    endtask

    // too many tasks, then a zero period later in the same set; first error sticks
    task automatic test_set_overflow();
        gaps_on = 1'b1;
        for (int i = 0; i < MAX_TASKS + 1; i++)
            send_task_beat(16'd1, 16'd1000, 1'b0);
        send_task_beat(16'd5, 16'd0, 1'b1);
    endtask

    task automatic test_random_sets(input int target);
        int kind, len, pct, base, zero_at;
        logic [TICK_W-1:0] wc, per;
        logic last;
        while (beats_sent < target) begin
            kind    = $urandom_range(0, 99);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (kind >= 85) begin
                // noise: raw fields, ragged set boundaries
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    wc   = TICK_W'($urandom);
                    per  = ($urandom_range(0, 15) == 0) ? '0 : TICK_W'($urandom);
                    last = ($urandom_range(0, 2) == 0);
                    send_task_beat(wc, per, last);
                end
            end else begin
                if (kind >= 75) len = $urandom_range(30, 40);
                else if ($urandom_range(0, 4) == 0) len = $urandom_range(9, 20);
                else len = $urandom_range(1, 8);
                pct     = $urandom_range(55, 112);
                zero_at = (kind >= 60 && kind < 75) ? $urandom_range(0, len - 1) : -1;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 3) == 0) per = TICK_W'($urandom_range(1, 64));
                    else per = TICK_W'($urandom_range(1, 65535));
                    // per-task share aimed so the set lands around the bound
                    base = (int'(per) * pct) / (100 * len);
                    wc   = TICK_W'($urandom_range(base * 9 / 10, base));
                    if (i == zero_at) begin
                        per = '0;
                        wc  = TICK_W'($urandom);
                    end
                    send_task_beat(wc, per, i == len - 1);
                end
            end
        end
        if (set_count != '0) send_task_beat(16'd0, 16'd1, 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_task_wcet   = '0;
        i_task_period = '0;
        i_last_task   = 1'b0;
        util_sum      = '0;
        set_count     = '0;
        set_status    = ST_OK;
        burst_left    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_sets();
        test_set_overflow();
        test_random_sets(RANDOM_BEATS);
        i_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d task beats in %0d cycles, checked %0d set verdicts",
                 beats_sent, cycle_count, n_verdicts);
        $display("verdicts: %0d schedulable, %0d zero period, %0d over task limit, %0d saturated",
                 n_sched, n_zero_period, n_too_many, n_saturated);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
